>>> rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [1:0] TRAIL_TAG  = 2'b10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    logic        string_bad;
  } unit_item_t;

  // One queue entry: one result, or two for a surrogate pair.
  typedef struct packed {
    logic [15:0] first_unit;
    logic [15:0] second_unit;
    logic        pair;
    logic        first_valid;
    logic        done;
    logic        bad;
  } work_t;

endpackage

>>> rtl/u8u16_front.sv
// Front end: validates UTF-8 bytes and turns each valid finished sequence or string end into a queue entry.
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  input  logic       q_full,
  output logic       push,
  output work_t      push_entry
);

  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  trail_left, trail_left_next;
  logic [1:0]  seq_length, seq_length_next;
  logic        error_seen, error_next;

  logic [7:0]  b;
  logic        last;
  logic        accept;
  logic        complete;
  logic        cp_bad;
  logic [20:0] cp;
  logic [20:0] offset;
  logic        have_unit;
  logic        pair;
  logic [15:0] unit_a;
  logic [15:0] unit_b;
  logic        final_bad;

  assign b          = byte_item.in_byte;
  assign last       = byte_item.end_of_string;
  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    code_accum_next = code_accum;
    trail_left_next = trail_left;
    seq_length_next = seq_length;
    error_next      = error_seen;
    complete        = 1'b0;
    cp              = '0;
    offset          = '0;
    cp_bad          = 1'b0;
    have_unit       = 1'b0;
    pair            = 1'b0;
    unit_a          = '0;
    unit_b          = '0;
    if (!error_seen) begin
      if (trail_left == 2'd0) begin
        priority if (!b[7]) begin
          cp              = {13'd0, b};
          seq_length_next = 2'd0;
          complete        = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          code_accum_next = {16'd0, b[4:0]};
          seq_length_next = 2'd1;
          trail_left_next = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          code_accum_next = {17'd0, b[3:0]};
          seq_length_next = 2'd2;
          trail_left_next = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          code_accum_next = {18'd0, b[2:0]};
          seq_length_next = 2'd3;
          trail_left_next = 2'd3;
        end else begin
          error_next = 1'b1;
        end
      end else if (b[7:6] != TRAIL_TAG) begin
        error_next = 1'b1;
      end else begin
        code_accum_next = {code_accum[14:0], b[5:0]};
        trail_left_next = trail_left - 2'd1;
        if (trail_left_next == 2'd0) begin
          cp       = code_accum_next;
          complete = 1'b1;
        end
      end

      if (complete) begin
        cp_bad = (seq_length_next == 2'd1 && cp < MIN_TWO_BYTE) ||
                 (seq_length_next == 2'd2 && cp < MIN_THREE_BYTE) ||
                 (seq_length_next == 2'd3 && cp < SUPP_BASE) ||
                 (cp > MAX_CODE_POINT) ||
                 (cp >= SURR_FIRST && cp <= SURR_LAST);
        if (cp_bad) begin
          error_next = 1'b1;
        end else if (cp < SUPP_BASE) begin
          have_unit = 1'b1;
          unit_a    = cp[15:0];
        end else begin
          offset    = cp - SUPP_BASE;
          have_unit = 1'b1;
          pair      = 1'b1;
          unit_a    = {HIGH_SURR_TAG, offset[19:10]};
          unit_b    = {LOW_SURR_TAG, offset[9:0]};
        end
        code_accum_next = '0;
        seq_length_next = 2'd0;
      end

      if (error_next) begin
        have_unit       = 1'b0;
        pair            = 1'b0;
        code_accum_next = '0;
        trail_left_next = 2'd0;
        seq_length_next = 2'd0;
      end
    end
  end

  assign final_bad = error_next || (trail_left_next != 2'd0);

  always_comb begin
    push_entry = '0;
    push       = accept && (last || have_unit);
    if (last && final_bad) begin
      push_entry.done = 1'b1;
      push_entry.bad  = 1'b1;
    end else begin
      push_entry.first_unit  = unit_a;
      push_entry.second_unit = unit_b;
      push_entry.pair        = pair;
      push_entry.first_valid = have_unit;
      push_entry.done        = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      code_accum <= '0;
      trail_left <= '0;
      seq_length <= '0;
      error_seen <= 1'b0;
    end else if (accept) begin
      code_accum <= code_accum_next;
      trail_left <= trail_left_next;
      seq_length <= seq_length_next;
      error_seen <= error_next;
    end
  end

  a_error_clears_sequence: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (trail_left == 2'd0 && seq_length == 2'd0 && code_accum == '0))
    else $error("sequence state not cleared after an error");

  a_trail_matches_length: assert property (@(posedge clk) disable iff (rst)
    trail_left <= seq_length)
    else $error("more trail bytes pending than the sequence holds");

endmodule

>>> rtl/u8u16_queue.sv
// Short queue of decoded entries between the front and back ends.
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_entry,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("transfer pushed into a full queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule

>>> rtl/u8u16_back.sv
// Back end: unpacks queue entries into single UTF-16 results behind an output register.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  work_t      head,
  input  logic       not_empty,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output unit_item_t res_item
);

  work_t cur;
  logic  cur_valid;
  logic  second;
  logic  last_phase;

  assign last_phase = !cur.pair || second;
  assign pop        = not_empty && (!cur_valid || (res_ready && last_phase));
  assign res_valid  = cur_valid;

  always_comb begin
    res_item = '0;
    if (cur.pair && !second) begin
      res_item.code_unit  = cur.first_unit;
      res_item.unit_valid = 1'b1;
    end else if (cur.pair) begin
      res_item.code_unit   = cur.second_unit;
      res_item.unit_valid  = 1'b1;
      res_item.string_done = cur.done;
    end else begin
      res_item.code_unit   = cur.first_unit;
      res_item.unit_valid  = cur.first_valid;
      res_item.string_done = cur.done;
      res_item.string_bad  = cur.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      second    <= 1'b0;
    end else if (cur_valid && res_ready) begin
      if (last_phase) begin
        cur_valid <= 1'b0;
        second    <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

  a_second_only_for_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> (cur_valid && cur.pair))
    else $error("second half shown for an entry without a pair");

  a_bad_is_empty_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.string_bad) |-> (res_item.string_done && !res_item.unit_valid))
    else $error("rejected string result carries a unit");

endmodule

>>> rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
//  Channel  Direction  Handshake                Payload
//  byte     in         byte_valid / byte_ready  byte_item (in_byte, end_of_string)
//  res      out        res_valid / res_ready    res_item (code_unit, unit_valid,
//                                                         string_done, string_bad)
//
// One byte is accepted per cycle while the entry queue has room; one result leaves per cycle
// while res_ready is high. A surrogate pair leaves as two results from a single queue entry.
// A result passes through a queue slot and then the back end's output register before it is visible.
// The synchronous reset empties the queue and the output register and clears the decoder.
// A stall on res only reaches byte_ready once QUEUE_DEPTH entries are waiting.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       res_valid,
  input  logic       res_ready,
  output unit_item_t res_item
);

  logic  push;
  work_t push_entry;
  logic  pop;
  work_t head;
  logic  q_full;
  logic  not_empty;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .not_empty  (not_empty)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

>>> tb/sv/utf8_to_utf16_transcoder_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder with random flow control.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb
  import u8u16_pkg::*;
();

  localparam logic [20:0] SCALAR_MAX  = 21'h10FFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [15:0] HIGH_HALF   = 16'hD800;
  localparam logic [15:0] LOW_HALF    = 16'hDC00;

  typedef enum int {
    BRK_RANDOM_BYTE,
    BRK_TRUNCATED,
    BRK_OVERLONG,
    BRK_SURROGATE,
    BRK_ABOVE_MAX,
    BRK_BAD_TRAIL
  } breakage_e;

  logic       clk;
  logic       rst        = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item  = '0;
  logic       res_valid;
  logic       res_ready  = 1'b0;
  unit_item_t res_item;

  logic [20:0] cp_accum;
  logic [1:0]  trail_count;
  logic [1:0]  seq_trails;
  logic        string_err;

  unit_item_t  expected_units[$];
  logic [7:0]  string_bytes[$];

  logic src_idle  = 1'b1;
  logic sink_idle = 1'b1;
  int   error_count;
  int   bytes_sent;
  int   strings_sent;
  int   units_seen;
  int   ends_seen;
  int   rejects_seen;

  utf8_to_utf16_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_decoder();
    cp_accum    = '0;
    trail_count = '0;
    seq_trails  = '0;
    string_err  = 1'b0;
  endfunction

  function automatic void push_unit(logic [15:0] unit, logic valid, logic done, logic bad);
    expected_units.push_back('{code_unit: unit, unit_valid: valid, string_done: done,
                               string_bad: bad});
  endfunction

  // Works out the code units that one accepted byte releases.
  function automatic void predict_units(logic [7:0] value, logic last);
    logic [15:0] units [2];
    int          n;
    logic        complete;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] offset;
    n        = 0;
    complete = 1'b0;
    cp       = '0;
    if (!string_err) begin
      if (trail_count == 2'd0) begin
        if (value[7] == 1'b0) begin
          cp         = {13'd0, value};
          seq_trails = 2'd0;
          complete   = 1'b1;
        end else if (value[7:5] == 3'b110) begin
          cp_accum    = {16'd0, value[4:0]};
          seq_trails  = 2'd1;
          trail_count = 2'd1;
        end else if (value[7:4] == 4'b1110) begin
          cp_accum    = {17'd0, value[3:0]};
          seq_trails  = 2'd2;
          trail_count = 2'd2;
        end else if (value[7:3] == 5'b11110) begin
          cp_accum    = {18'd0, value[2:0]};
          seq_trails  = 2'd3;
          trail_count = 2'd3;
        end else begin
          string_err = 1'b1;
        end
      end else if (value[7:6] != 2'b10) begin
        string_err = 1'b1;
      end else begin
        cp_accum    = {cp_accum[14:0], value[5:0]};
        trail_count = trail_count - 2'd1;
        if (trail_count == 2'd0) begin
          cp       = cp_accum;
          complete = 1'b1;
        end
      end

      if (complete) begin
        bad = (seq_trails == 2'd1 && cp < 21'h80) || (seq_trails == 2'd2 && cp < 21'h800) ||
              (seq_trails == 2'd3 && cp < PLANE1_BASE) || cp > SCALAR_MAX ||
              (cp >= SURR_LO && cp <= SURR_HI);
        if (bad) begin
          string_err = 1'b1;
        end else if (cp < PLANE1_BASE) begin
          units[n] = cp[15:0];
          n++;
        end else begin
          offset   = cp - PLANE1_BASE;
          units[n] = HIGH_HALF + 16'(offset[19:10]);
          n++;
          units[n] = LOW_HALF + 16'(offset[9:0]);
          n++;
        end
        cp_accum   = '0;
        seq_trails = '0;
      end

      if (string_err) begin
        n           = 0;
        cp_accum    = '0;
        trail_count = '0;
        seq_trails  = '0;
      end
    end

    if (!last) begin
      for (int k = 0; k < n; k++) push_unit(units[k], 1'b1, 1'b0, 1'b0);
    end else begin
      if (trail_count != 2'd0) string_err = 1'b1;
      if (string_err) begin
        push_unit('0, 1'b0, 1'b1, 1'b1);
      end else if (n == 0) begin
        push_unit('0, 1'b0, 1'b1, 1'b0);
      end else begin
        for (int k = 0; k < n; k++) push_unit(units[k], 1'b1, k == n - 1, 1'b0);
      end
      clear_decoder();
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{in_byte: value, end_of_string: last};
    do @(posedge clk); while (!byte_ready);
    predict_units(value, last);
    bytes_sent++;
  endtask

  task automatic flush_string();
    for (int i = 0; i < string_bytes.size(); i++)
      send_byte(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
    strings_sent++;
  endtask

  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  function automatic void push_encoded(logic [20:0] cp, int len);
    case (len)
      1: string_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        string_bytes.push_back({3'b110, cp[10:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, cp[15:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        string_bytes.push_back({5'b11110, cp[20:18]});
        string_bytes.push_back({2'b10, cp[17:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] random_code_point(int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= SURR_LO) cp = cp + 21'h800;
      end
      default: cp = 21'($urandom_range(PLANE1_BASE, SCALAR_MAX));
    endcase
    return cp;
  endfunction

  function automatic void push_broken_sequence();
    breakage_e   kind;
    int          len;
    logic [1:0]  tag;
    kind = breakage_e'($urandom_range(BRK_RANDOM_BYTE, BRK_BAD_TRAIL));
    len  = $urandom_range(2, 4);
    case (kind)
      BRK_RANDOM_BYTE: string_bytes.push_back(8'($urandom_range(0, 255)));
      BRK_TRUNCATED: begin
        push_encoded(random_code_point(len), len);
        void'(string_bytes.pop_back());
      end
      BRK_OVERLONG:  push_encoded(random_code_point(len - 1), len);
      BRK_SURROGATE: push_encoded(21'($urandom_range(SURR_LO, SURR_HI)), 3);
      BRK_ABOVE_MAX: push_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      default: begin
        push_encoded(random_code_point(len), len);
        do tag = 2'($urandom_range(0, 3)); while (tag == 2'b10);
        string_bytes[string_bytes.size() - 1][7:6] = tag;
      end
    endcase
  endfunction

  task automatic send_random_string();
    int n_points;
    int len;
    n_points = $urandom_range(1, 8);
    repeat (n_points) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 4);
        push_encoded(random_code_point(len), len);
      end else begin
        push_broken_sequence();
      end
    end
    flush_string();
  endtask

  task automatic run_random_strings(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_string();
    wait_for_drain();
  endtask

  task automatic test_valid_extremes();
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    string_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF};
    flush_string();
    wait_for_drain();
  endtask

  task automatic test_malformed_strings();
    string_bytes = '{8'hFF, 8'h41};
    flush_string();
    string_bytes = '{8'hC2, 8'h41};
    flush_string();
    string_bytes = '{8'hC0, 8'h80};
    flush_string();
    string_bytes = '{8'hED, 8'hA0, 8'h80};
    flush_string();
    string_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
    flush_string();
    string_bytes = '{8'hE2, 8'h82};
    flush_string();
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_random_strings(300);
  endtask

  task automatic test_output_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    run_random_strings(300);
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_random_strings(300);
  endtask

  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      stall = sink_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    unit_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h/%b/%b/%b", $time,
                 res_item.code_unit, res_item.unit_valid, res_item.string_done,
                 res_item.string_bad);
        error_count++;
      end else begin
        want = expected_units.pop_front();
        check_field("code_unit", want.code_unit, res_item.code_unit);
        check_field("unit_valid", 16'(want.unit_valid), 16'(res_item.unit_valid));
        check_field("string_done", 16'(want.string_done), 16'(res_item.string_done));
        check_field("string_bad", 16'(want.string_bad), 16'(res_item.string_bad));
        if (want.unit_valid) units_seen++;
        if (want.string_done) ends_seen++;
        if (want.string_bad) rejects_seen++;
      end
    end
  end

  initial begin
    clear_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_valid_extremes();
    test_malformed_strings();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();
    wait_for_drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d bytes in %0d strings under mixed idling and back-pressure.",
             bytes_sent, strings_sent);
    $display("Checked %0d code units and %0d string ends, %0d of them rejected.",
             units_seen, ends_seen, rejects_seen);
    if (error_count == 0) begin
      $display("** utf8_to_utf16_transcoder: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("Run timed out with %0d results outstanding.", expected_units.size());
    $display("** utf8_to_utf16_transcoder: FAILED **");
    $finish;
  end

endmodule
